/* rtl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, stage numbers and types shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

    // Q16.16 entries, their count and the tolerance width
    localparam int DATA_W   = 32;
    localparam int N_ENT    = 9;
    localparam int TOL_W    = 32;

    // exact intermediate widths
    localparam int PROD_W   = 64;   // entry times entry
    localparam int COF_W    = 65;   // cofactor, Q32.32
    localparam int PART_W   = 65;   // 33 x 32 partial product of the determinant
    localparam int DET_W    = 98;   // determinant, Q48.48
    localparam int ADET_W   = 97;   // magnitude of the determinant
    localparam int SUM_W    = 36;   // sum of nine magnitudes
    localparam int THR_W    = 68;   // sum times tolerance
    localparam int DEN_W    = 98;   // twice the magnitude of the determinant
    localparam int REM_W    = 131;  // running remainder of the divider

    // pipeline map: stages 1..6 form the determinant, the divider lanes
    // occupy stages FIRST_DIV..NS-1 and stage NS is the output register
    localparam int QBITS      = 32;
    localparam int DIV_STAGES = QBITS + 1;
    localparam int FIRST_DIV  = 7;
    localparam int NS         = FIRST_DIV + DIV_STAGES;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic signed [COF_W-1:0]  cof_t;

    // saturation limits of a Q16.16 magnitude
    localparam logic [QBITS-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [QBITS-1:0] LIM_NEG = 32'h8000_0000;

endpackage

`default_nettype wire

/* rtl/matrix_inverse_3x3.sv */
// Throughput: one matrix per cycle unless the result channel stalls; the 32 single-bit divider stages set the depth.
// A stage moves on when it is empty or the stage after it moves, so bubbles close up.
// Reset (aresetn low, synchronous) empties the pipeline and sets tolerance to 1.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed Q16.16 3x3 matrix by the adjugate, with a singularity
// test against a tolerance register and saturation of the result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_3x3 import mi3_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // tolerance register, unsigned Q0.32
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [TOL_W-1:0]           cfg_data,
    // input matrix
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [N_ENT*DATA_W-1:0]    s_tdata,  // a00,a01,a02,a10,..,a22
    // inverse
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [N_ENT*DATA_W-1:0]    m_tdata,  // inv00,inv01,..,inv22
    output logic      [1:0]                 m_tuser   // singular, saturated
);

    // ------------------------------------------------------------------
    // tolerance register
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_W'(1);
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // stage valids and load enables
    // ------------------------------------------------------------------
    logic [NS:1]   v_reg;
    logic [NS+1:1] en;

    always_comb begin
        en[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: cofactor products and sum of magnitudes
    // ------------------------------------------------------------------
    q16_t                     a    [N_ENT];
    logic signed [PROD_W-1:0] pa_next [N_ENT];
    logic signed [PROD_W-1:0] pb_next [N_ENT];
    logic [SUM_W-1:0]         sum_next;

    logic signed [PROD_W-1:0] pa_reg [N_ENT];
    logic signed [PROD_W-1:0] pb_reg [N_ENT];
    logic [SUM_W-1:0]         sum_reg;
    q16_t                     m0_s1_reg [3];

    always_comb begin
        sum_next = '0;
        for (int e = 0; e < N_ENT; e++) begin
            a[e]     = q16_t'(s_tdata[e*DATA_W +: DATA_W]);
            // magnitude is unsigned: -2^31 gives 2^31
            sum_next = sum_next + SUM_W'($unsigned(a[e][DATA_W-1] ? DATA_W'(-a[e])
                                                                  : DATA_W'(a[e])));
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pa_next[i*3+j] = PROD_W'(a[((i+1)%3)*3 + (j+1)%3])
                               * PROD_W'(a[((i+2)%3)*3 + (j+2)%3]);
                pb_next[i*3+j] = PROD_W'(a[((i+1)%3)*3 + (j+2)%3])
                               * PROD_W'(a[((i+2)%3)*3 + (j+1)%3]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            sum_reg <= sum_next;
            for (int j = 0; j < 3; j++) begin
                m0_s1_reg[j] <= a[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cofactors and singularity threshold
    // ------------------------------------------------------------------
    cof_t             cof_s2_reg [N_ENT];
    logic [THR_W-1:0] thr_s2_reg;
    q16_t             m0_s2_reg [3];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int e = 0; e < N_ENT; e++) begin
                cof_s2_reg[e] <= COF_W'(pa_reg[e]) - COF_W'(pb_reg[e]);
            end
            thr_s2_reg <= THR_W'(sum_reg) * THR_W'(tol_reg);
            m0_s2_reg  <= m0_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: first-row partial products, cofactor split at bit 32
    // ------------------------------------------------------------------
    logic signed [PART_W-1:0] ph_reg [3];
    logic signed [PART_W-1:0] pl_reg [3];
    cof_t                     cof_s3_reg [N_ENT];
    logic [THR_W-1:0]         thr_s3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                ph_reg[j] <= PART_W'($signed(cof_s2_reg[j][COF_W-1:DATA_W]))
                           * PART_W'(m0_s2_reg[j]);
                pl_reg[j] <= PART_W'($signed({1'b0, cof_s2_reg[j][DATA_W-1:0]}))
                           * PART_W'(m0_s2_reg[j]);
            end
            cof_s3_reg <= cof_s2_reg;
            thr_s3_reg <= thr_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: recombine each first-row term
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] t_reg [3];
    cof_t                    cof_s4_reg [N_ENT];
    logic [THR_W-1:0]        thr_s4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int j = 0; j < 3; j++) begin
                t_reg[j] <= (DET_W'(ph_reg[j]) <<< DATA_W) + DET_W'(pl_reg[j]);
            end
            cof_s4_reg <= cof_s3_reg;
            thr_s4_reg <= thr_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: determinant
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] det_reg;
    cof_t                    cof_s5_reg [N_ENT];
    logic [THR_W-1:0]        thr_s5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            det_reg    <= t_reg[0] + t_reg[1] + t_reg[2];
            cof_s5_reg <= cof_s4_reg;
            thr_s5_reg <= thr_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: magnitudes, signs and the singularity decision
    // ------------------------------------------------------------------
    logic [ADET_W-1:0] adet_next;
    logic [ADET_W-1:0] adet_reg;
    logic [COF_W-1:0]  cmag_reg [N_ENT];
    logic              neg_reg  [N_ENT];
    logic              sing_reg [FIRST_DIV-1:NS-1];

    always_comb begin
        adet_next = det_reg[DET_W-1] ? ADET_W'(-det_reg) : ADET_W'(det_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            adet_reg              <= adet_next;
            sing_reg[FIRST_DIV-1] <= adet_next <= ADET_W'(thr_s5_reg);
            // lane (i,j) divides the transposed cofactor (j,i)
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cmag_reg[i*3+j] <= cof_s5_reg[j*3+i][COF_W-1]
                                     ? COF_W'(-cof_s5_reg[j*3+i])
                                     : COF_W'(cof_s5_reg[j*3+i]);
                    neg_reg[i*3+j]  <= cof_s5_reg[j*3+i][COF_W-1] ^ det_reg[DET_W-1];
                end
            end
        end
    end

    // carry the singular flag alongside the divider
    always_ff @(posedge aclk) begin
        for (int k = FIRST_DIV; k <= NS-1; k++) begin
            if (en[k]) begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 7..39: nine divider lanes
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] lane_res [N_ENT];
    logic [N_ENT-1:0]  lane_sat;

    for (genvar e = 0; e < N_ENT; e++) begin : g_lane
        mi3_div_lane u_lane (
            .aclk  (aclk),
            .en    (en[FIRST_DIV +: DIV_STAGES]),
            .c_mag (cmag_reg[e]),
            .adet  (adet_reg),
            .neg   (neg_reg[e]),
            .res   (lane_res[e]),
            .sat   (lane_sat[e])
        );
    end

    // ------------------------------------------------------------------
    // stage 40: output register, zero everything for a singular matrix
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] inv_reg [N_ENT];
    logic              osing_reg;
    logic              osat_reg;

    always_ff @(posedge aclk) begin
        if (en[NS]) begin
            for (int e = 0; e < N_ENT; e++) begin
                inv_reg[e] <= sing_reg[NS-1] ? '0 : lane_res[e];
            end
            osing_reg <= sing_reg[NS-1];
            osat_reg  <= !sing_reg[NS-1] && (|lane_sat);
        end
    end

    always_comb begin
        for (int e = 0; e < N_ENT; e++) begin
            m_tdata[e*DATA_W +: DATA_W] = inv_reg[e];
        end
    end

    assign m_tvalid = v_reg[NS];
    assign m_tuser  = {osat_reg, osing_reg};

`ifndef NO_ASSERTIONS
    // a singular result never reports clipping
    a_sing_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("singular result flagged as saturated");

    // a singular result carries an all-zero matrix
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result with non-zero entries");

    // input is held off only when every stage is occupied
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&v_reg) && !m_tready)
        else $error("input stalled with a free pipeline stage");
`endif

endmodule

`default_nettype wire

/* rtl/mi3_div_lane.sv */
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one inverse entry: one quotient bit per
// stage, rounding to nearest and saturation to Q16.16 on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane import mi3_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic [DIV_STAGES-1:0] en,       // load enable of each stage
    input  wire logic [COF_W-1:0]      c_mag,    // magnitude of the cofactor
    input  wire logic [ADET_W-1:0]     adet,     // magnitude of the determinant
    input  wire logic                  neg,      // sign of the quotient
    output logic      [DATA_W-1:0]     res,      // saturated Q16.16 entry
    output logic                       sat       // entry was clipped
);

    logic [REM_W-1:0] r_reg   [DIV_STAGES];
    logic [DEN_W-1:0] d_reg   [DIV_STAGES];
    logic [QBITS-1:0] q_reg   [DIV_STAGES];
    logic             ovf_reg [DIV_STAGES];
    logic             neg_reg [DIV_STAGES];

    logic [REM_W-1:0] n_next;
    logic [DEN_W-1:0] d_next;
    logic             ovf_next;

    // numerator 2*c*2^32 + |det| over 2*|det| rounds half away from zero
    always_comb begin
        n_next   = (REM_W'(c_mag) << (QBITS + 1)) + REM_W'(adet);
        d_next   = {adet, 1'b0};
        ovf_next = n_next >= (REM_W'(d_next) << QBITS);
    end

    // entry stage: form operands, flag quotients of 2^32 and above
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r_reg[0]   <= n_next;
            d_reg[0]   <= d_next;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_bit
        localparam int K = QBITS - s;
        logic [REM_W-1:0] dk_next;
        logic             ge_next;

        always_comb begin
            dk_next = REM_W'(d_reg[s-1]) << K;
            ge_next = r_reg[s-1] >= dk_next;
        end

        always_ff @(posedge aclk) begin
            if (en[s]) begin
                r_reg[s]   <= ge_next ? (r_reg[s-1] - dk_next) : r_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (QBITS'(ge_next) << K);
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // clip to the signed range and apply the sign
    logic [QBITS-1:0] limit;
    logic [QBITS-1:0] mag;

    always_comb begin
        limit = neg_reg[DIV_STAGES-1] ? LIM_NEG : LIM_POS;
        sat   = ovf_reg[DIV_STAGES-1] || (q_reg[DIV_STAGES-1] > limit);
        mag   = sat ? limit : q_reg[DIV_STAGES-1];
        res   = neg_reg[DIV_STAGES-1] ? DATA_W'(-mag) : DATA_W'(mag);
    end

endmodule

`default_nettype wire

/* tb/matrix_inverse_3x3_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker
// Watches the tolerance, input and result channels of the 3x3 inverse and
// computes each expected inverse exactly with wide integers. Every result
// transaction is compared field by field with the oldest expected inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_3x3_checker import mi3_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [TOL_W-1:0]        cfg_data,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [N_ENT*DATA_W-1:0] s_tdata,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [N_ENT*DATA_W-1:0] m_tdata,
    input  wire logic [1:0]              m_tuser,
    output int                           fail_count,
    output int                           inverse_pending,
    output int                           matrices_seen,
    output int                           singular_seen,
    output int                           saturated_seen,
    output int                           tol_writes
);

    typedef struct {
        logic [DATA_W-1:0] ent [N_ENT];
        logic              singular;
        logic              saturated;
    } inverse_t;

    inverse_t             inverse_q [$];
    logic [TOL_W-1:0]     tol_shadow;

    // Exact inverse by the adjugate, rounded half away from zero, saturated
    function automatic inverse_t invert(input logic [N_ENT*DATA_W-1:0] mat,
                                        input logic [TOL_W-1:0] tol);
        inverse_t           r;
        logic signed [127:0] m [9];
        logic signed [127:0] cof [3][3];
        logic signed [127:0] det, adet, thr, sum, c, ac, q, lim;
        logic                neg;
        int                  i, j, i1, i2, j1, j2;
        sum = 0;
        for (i = 0; i < 9; i++) begin
            m[i] = 128'(signed'(mat[i*DATA_W +: DATA_W]));
            sum  = sum + ((m[i] < 0) ? -m[i] : m[i]);
        end
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                cof[i][j] = m[i1*3+j1] * m[i2*3+j2] - m[i1*3+j2] * m[i2*3+j1];
            end
        end
        det  = cof[0][0] * m[0] + cof[0][1] * m[1] + cof[0][2] * m[2];
        adet = (det < 0) ? -det : det;
        thr  = sum * $signed({96'd0, tol});
        r.singular  = 1'b0;
        r.saturated = 1'b0;
        if (adet <= thr) begin
            for (i = 0; i < 9; i++) r.ent[i] = '0;
            r.singular = 1'b1;
            return r;
        end
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                c   = cof[j][i];
                ac  = (c < 0) ? -c : c;
                neg = (c < 0) != (det < 0);
                if (ac == 0) begin
                    r.ent[i*3+j] = '0;
                end else begin
                    q   = ((ac <<< 33) + adet) / (adet <<< 1);
                    lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
                    if (q > lim) begin
                        q = lim;
                        r.saturated = 1'b1;
                    end
                    q = neg ? -q : q;
                    r.ent[i*3+j] = q[DATA_W-1:0];
                end
            end
        end
        return r;
    endfunction

    assign inverse_pending = inverse_q.size();

    // Track the register, queue predictions and compare results
    always @(posedge aclk) begin
        inverse_t exp_inv;
        int       k;
        int       errs;
        if (!aresetn) begin
            tol_shadow = 32'd1;
            inverse_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                tol_shadow = cfg_data;
                tol_writes <= tol_writes + 1;
            end
            if (s_tvalid && s_tready) begin
                inverse_q.push_back(invert(s_tdata, tol_shadow));
                matrices_seen <= matrices_seen + 1;
            end
            if (m_tvalid && m_tready) begin
                errs = 0;
                if (m_tuser[0]) singular_seen <= singular_seen + 1;
                if (m_tuser[1]) saturated_seen <= saturated_seen + 1;
                if (inverse_q.size() == 0) begin
                    $error("result transaction with no matrix outstanding");
                    errs = errs + 1;
                end else begin
                    exp_inv = inverse_q.pop_front();
                    for (k = 0; k < N_ENT; k++) begin
                        if (m_tdata[k*DATA_W +: DATA_W] !== exp_inv.ent[k]) begin
                            $error("inv%0d%0d: expected %h, got %h", k / 3, k % 3,
                                   exp_inv.ent[k], m_tdata[k*DATA_W +: DATA_W]);
                            errs = errs + 1;
                        end
                    end
                    if (m_tuser[0] !== exp_inv.singular) begin
                        $error("singular: expected %b, got %b", exp_inv.singular,
                               m_tuser[0]);
                        errs = errs + 1;
                    end
                    if (m_tuser[1] !== exp_inv.saturated) begin
                        $error("saturated: expected %b, got %b", exp_inv.saturated,
                               m_tuser[1]);
                        errs = errs + 1;
                    end
                end
                if (errs != 0) fail_count <= fail_count + errs;
            end
        end
    end

    initial begin
        fail_count     = 0;
        matrices_seen  = 0;
        singular_seen  = 0;
        saturated_seen = 0;
        tol_writes     = 0;
        tol_shadow     = 32'd1;
    end

endmodule

`default_nettype wire

/* tb/tb_matrix_inverse_3x3.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// Drives directed and random matrices through the 3x3 inverse under several
// tolerance settings, with random gaps on both channels, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_inverse_3x3;
    import mi3_pkg::*;

    localparam int LATENCY   = 40;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1850;
    localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TOL_W-1:0]        cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [N_ENT*DATA_W-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [N_ENT*DATA_W-1:0] m_tdata;
    logic [1:0]              m_tuser;

    int fail_count, inverse_pending, matrices_seen, singular_seen;
    int saturated_seen, tol_writes;
    int idle_cycles;
    int stall_burst;

    matrix_inverse_3x3 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    matrix_inverse_3x3_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .inverse_pending (inverse_pending),
        .matrices_seen   (matrices_seen),
        .singular_seen   (singular_seen),
        .saturated_seen  (saturated_seen),
        .tol_writes      (tol_writes)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, otherwise a short gap or now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Randomly stall the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_burst <= 0;
        end else if (stall_burst > 0) begin
            m_tready    <= 1'b0;
            stall_burst <= stall_burst - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready    <= 1'b0;
            stall_burst <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Count cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_MAX);
            $display("matrix_inverse_3x3: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [N_ENT*DATA_W-1:0] pack9(input logic [DATA_W-1:0] e [N_ENT]);
        logic [N_ENT*DATA_W-1:0] v;
        for (int k = 0; k < N_ENT; k++) v[k*DATA_W +: DATA_W] = e[k];
        return v;
    endfunction

    function automatic logic [N_ENT*DATA_W-1:0] diag(input logic [DATA_W-1:0] d0,
            input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2);
        logic [DATA_W-1:0] e [N_ENT];
        for (int k = 0; k < N_ENT; k++) e[k] = '0;
        e[0] = d0; e[4] = d1; e[8] = d2;
        return pack9(e);
    endfunction

    function automatic logic [DATA_W-1:0] small_entry();
        return DATA_W'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
    endfunction

    // Random matrix of one of several shapes
    function automatic logic [N_ENT*DATA_W-1:0] rand_matrix();
        logic [DATA_W-1:0] e [N_ENT];
        int kind, k, sh;
        kind = $urandom_range(0, 9);
        for (k = 0; k < N_ENT; k++) e[k] = $urandom();
        case (kind)
            0, 1: begin
                // full-range entries
            end
            2, 3, 4: begin
                for (k = 0; k < N_ENT; k++) e[k] = small_entry();
            end
            5: begin
                // large diagonal: 16.0 added to two diagonal entries, taken from the third
                for (k = 0; k < N_ENT; k++) e[k] = small_entry();
                e[0] = e[0] + 32'h0010_0000;
                e[4] = e[4] + 32'h0010_0000;
                e[8] = e[8] - 32'h0010_0000;
            end
            6: begin
                // exactly singular: third row is the sum of the other two
                for (k = 0; k < 6; k++) e[k] = small_entry();
                for (k = 0; k < 3; k++) e[6+k] = e[k] + e[3+k];
            end
            7: begin
                // nearly singular: dependent row plus a tiny perturbation
                for (k = 0; k < 6; k++) e[k] = small_entry();
                for (k = 0; k < 3; k++) e[6+k] = e[k] - e[3+k] + $urandom_range(0, 3);
            end
            8: begin
                // entries scaled over a wide range of magnitudes
                sh = $urandom_range(0, 30);
                for (k = 0; k < N_ENT; k++) e[k] = DATA_W'($signed(e[k]) >>> sh);
            end
            default: begin
                // sparse matrix: each entry is zeroed with even odds
                for (k = 0; k < N_ENT; k++)
                    if ($urandom_range(0, 1) == 0) e[k] = '0;
            end
        endcase
        return pack9(e);
    endfunction

    task automatic send_matrix(input logic [N_ENT*DATA_W-1:0] mat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drain, let the pipeline settle, then write the tolerance
    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        s_tvalid <= 1'b0;
        while (inverse_pending != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) send_matrix(rand_matrix());
    endtask

    initial begin
        logic [DATA_W-1:0] e [N_ENT];
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed matrices under the reset tolerance
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix({N_ENT{32'h7FFF_FFFF}});
        send_matrix({N_ENT{32'h8000_0000}});
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'hFFFF_FFFF, ONE, 32'h0000_0002));
        send_matrix(diag(32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000));
        send_matrix(diag(32'h0000_0003, 32'h0002_0000, 32'h0001_8000));
        send_matrix(diag(32'h0001_0000, 32'h0000_4000, 32'h0002_0000));
        for (int k = 0; k < N_ENT; k++) e[k] = '0;
        e[1] = ONE; e[5] = 32'hFFFF_0000; e[6] = 32'h0002_0000;
        send_matrix(pack9(e));
        for (int k = 0; k < N_ENT; k++) e[k] = ONE;
        e[4] = 32'h0001_0001;
        send_matrix(pack9(e));
        for (int k = 0; k < N_ENT; k++) e[k] = 32'(k + 1) << 16;
        send_matrix(pack9(e));
        e[8] = 32'h000A_0000;
        send_matrix(pack9(e));
        send_matrix({N_ENT{32'hAAAA_AAAA}} ^ diag(ONE, '0, '0));
        send_matrix({N_ENT{32'h5555_5555}} ^ diag('0, ONE, 32'hFFFF_FFFF));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF) | 288'h1);
        random_phase(150);

        // Tolerance zero: only an exactly zero determinant is singular
        write_tolerance('0);
        send_matrix('0);
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        random_phase(350);

        // Largest tolerance
        write_tolerance('1);
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        random_phase(350);

        write_tolerance(32'h0001_0000);
        random_phase(350);

        write_tolerance($urandom());
        random_phase(300);

        write_tolerance(32'd1);
        random_phase(N_RANDOM - 1500);

        // Drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (inverse_pending != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);

        $display("covered %0d matrices under %0d tolerance writes",
                 matrices_seen, tol_writes);
        $display("results flagged singular %0d, saturated %0d",
                 singular_seen, saturated_seen);
        if (fail_count == 0) begin
            $display("matrix_inverse_3x3: match");
        end else begin
            $display("matrix_inverse_3x3: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/mi3_pkg.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_checker.sv
tb/tb_matrix_inverse_3x3.sv
